[rtl/core/csp_pkg.sv]
package csp_pkg;

    // Widest cursor row; wider shapes are clamped to this
    localparam int MAX_WIDTH = 256;
    // Tallest visible image; taller shapes are clamped to this
    localparam int ROW_LIMIT = 256;

    localparam int TYPE_W   = 2;
    localparam int SWIDTH_W = 9;
    localparam int RHEIGHT_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam int ITEM_W   = 48;

    localparam logic [TYPE_W-1:0] TYPE_COLOR  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_MASKED = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_MONO   = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_UNSUP  = 2'd3;

    localparam logic [1:0] MODE_ALPHA   = 2'd0;
    localparam logic [1:0] MODE_REPLACE = 2'd1;
    localparam logic [1:0] MODE_XOR     = 2'd2;
    localparam logic [1:0] MODE_ANDXOR  = 2'd3;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_ALPHA  = 2'd1;
    localparam logic [1:0] ERR_HEIGHT = 2'd2;
    localparam logic [1:0] ERR_TYPE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_HEIGHT  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [TYPE_W-1:0]    shape_type;
        logic [SWIDTH_W-1:0]  shape_width;
        logic [RHEIGHT_W-1:0] raw_height;
    } t_cfg;

    // Packed MSB first, so blue lands in bits 7:0
    typedef struct packed {
        logic [7:0] xor_mask_byte;
        logic [7:0] and_mask_byte;
        logic [7:0] alpha_in;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_item;

    typedef struct packed {
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [1:0] pixel_mode;
        logic [7:0] pixel_alpha;
        logic       last_of_item;
        logic [1:0] error_code;
    } t_result;

endpackage

[rtl/core/csp_cfg.sv]
module csp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [csp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output csp_pkg::t_cfg                 o_cfg,
    output logic                          o_clear
);
    import csp_pkg::*;

    logic [TYPE_W-1:0]    r_shape_type;
    logic [SWIDTH_W-1:0]  r_shape_width;
    logic [RHEIGHT_W-1:0] r_raw_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_type  <= TYPE_COLOR;
            r_shape_width <= SWIDTH_W'(32);
            r_raw_height  <= RHEIGHT_W'(32);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SHAPE_TYPE:  r_shape_type  <= i_cfg_data[TYPE_W-1:0];
                CFG_SHAPE_WIDTH: r_shape_width <= i_cfg_data[SWIDTH_W-1:0];
                CFG_RAW_HEIGHT:  r_raw_height  <= i_cfg_data[RHEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // A write to a known register restarts the shape
    assign o_clear = i_cfg_valid && (i_cfg_index == CFG_SHAPE_TYPE ||
                     i_cfg_index == CFG_SHAPE_WIDTH || i_cfg_index == CFG_RAW_HEIGHT);

    assign o_cfg.shape_type  = r_shape_type;
    assign o_cfg.shape_width = r_shape_width;
    assign o_cfg.raw_height  = r_raw_height;

endmodule

[rtl/core/csp_engine.sv]
module csp_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  csp_pkg::t_cfg                i_cfg,
    input  logic                         i_clear,
    input  logic                         i_item_valid,
    output logic                         o_item_ready,
    input  logic [csp_pkg::ITEM_W-1:0]   i_item,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output csp_pkg::t_result             o_res
);
    import csp_pkg::*;

    localparam logic [SWIDTH_W-1:0]  WIDTH_CAP  = SWIDTH_W'(MAX_WIDTH);
    localparam logic [RHEIGHT_W-1:0] HEIGHT_CAP = RHEIGHT_W'(ROW_LIMIT);

    logic        r_item_valid;
    t_item       r_item;
    logic [2:0]  r_bit;
    logic [7:0]  r_col;
    logic [7:0]  r_row;
    logic [1:0]  r_err;

    logic                 is_mono;
    logic                 geo_err;
    logic [SWIDTH_W-1:0]  w_eff;
    logic [RHEIGHT_W-1:0] h_half;
    logic [RHEIGHT_W-1:0] h_eff;
    logic [7:0]           col_cur;
    logic [7:0]           row_cur;
    logic [SWIDTH_W-1:0]  col_p1;
    logic [RHEIGHT_W-1:0] row_p1;
    logic                 col_wrap;
    logic                 row_wrap;
    logic                 bad_alpha;
    logic [1:0]           err_now;
    logic                 fire;
    logic                 done;
    logic [7:0]           n_col;
    logic [7:0]           n_row;
    t_result              res;

    always_comb begin
        is_mono = (i_cfg.shape_type == TYPE_MONO);
        w_eff   = (i_cfg.shape_width > WIDTH_CAP) ? WIDTH_CAP : i_cfg.shape_width;
        // Monochrome height counts both mask planes
        h_half  = is_mono ? {1'b0, i_cfg.raw_height[RHEIGHT_W-1:1]} : i_cfg.raw_height;
        geo_err = (is_mono && (i_cfg.raw_height == '0 || i_cfg.raw_height[0])) ||
                  (i_cfg.shape_width == '0) || (h_half == '0);
        h_eff   = (h_half > HEIGHT_CAP) ? HEIGHT_CAP : h_half;

        col_cur = ({1'b0, r_col} >= w_eff) ? 8'd0 : r_col;
        row_cur = ({2'b0, r_row} >= h_eff) ? 8'd0 : r_row;
        col_p1  = {1'b0, col_cur} + SWIDTH_W'(1);
        row_p1  = {2'b0, row_cur} + RHEIGHT_W'(1);
        col_wrap = (col_p1 >= w_eff);
        row_wrap = (row_p1 >= h_eff);

        bad_alpha = (r_item.alpha_in != 8'd0) && (r_item.alpha_in != ALPHA_OPAQUE);

        if (r_err != ERR_NONE) begin
            err_now = r_err;
        end else if (geo_err) begin
            err_now = ERR_HEIGHT;
        end else if (i_cfg.shape_type == TYPE_UNSUP) begin
            err_now = ERR_TYPE;
        end else if (i_cfg.shape_type == TYPE_MASKED && bad_alpha) begin
            err_now = ERR_ALPHA;
        end else begin
            err_now = ERR_NONE;
        end

        res = '0;
        res.pixel_x      = col_cur;
        res.pixel_y      = row_cur;
        res.last_of_item = 1'b1;
        case (i_cfg.shape_type)
            TYPE_COLOR: begin
                res.red_out     = r_item.red_in;
                res.green_out   = r_item.green_in;
                res.blue_out    = r_item.blue_in;
                res.pixel_mode  = MODE_ALPHA;
                res.pixel_alpha = r_item.alpha_in;
            end
            TYPE_MASKED: begin
                res.red_out    = r_item.red_in;
                res.green_out  = r_item.green_in;
                res.blue_out   = r_item.blue_in;
                res.pixel_mode = (r_item.alpha_in == 8'd0) ? MODE_REPLACE : MODE_XOR;
            end
            TYPE_MONO: begin
                // MSB first: bit index 0 takes mask bit 7
                res.red_out      = {7'd0, r_item.and_mask_byte[~r_bit]};
                res.green_out    = {7'd0, r_item.xor_mask_byte[~r_bit]};
                res.pixel_mode   = MODE_ANDXOR;
                res.last_of_item = (r_bit == 3'd7) || col_wrap;
            end
            default: ;
        endcase
        if (err_now != ERR_NONE) begin
            res = '0;
            res.last_of_item = 1'b1;
            res.error_code   = err_now;
        end

        if (col_wrap) begin
            n_col = 8'd0;
            n_row = row_wrap ? 8'd0 : row_p1[7:0];
        end else begin
            n_col = col_p1[7:0];
            n_row = row_cur;
        end
    end

    assign fire = r_item_valid && i_res_ready;
    assign done = fire && res.last_of_item;
    assign o_item_ready = !r_item_valid || done;
    assign o_res_valid  = r_item_valid;
    assign o_res        = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_item_valid && o_item_ready) begin
            r_item_valid <= 1'b1;
        end else if (done) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid && o_item_ready) begin
            r_item <= t_item'(i_item);
            r_bit  <= 3'd0;
        end else if (fire) begin
            r_bit  <= r_bit + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col <= 8'd0;
            r_row <= 8'd0;
            r_err <= ERR_NONE;
        end else if (fire) begin
            r_err <= err_now;
            if (err_now == ERR_NONE) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE && !i_clear) |=> (r_err == $past(r_err)))
        else $error("latched error changed without a register write");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_code != ERR_NONE) |->
        (o_res.last_of_item && o_res.pixel_x == 8'd0 && o_res.pixel_mode == MODE_ALPHA))
        else $error("error result not single and cleared");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_eff != '0) |-> ({1'b0, r_col} < w_eff))
        else $error("column counter beyond row width");

    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && err_now != ERR_NONE && !i_clear) |=> ($stable(r_col) && $stable(r_row)))
        else $error("counters moved on an error result");

endmodule

[rtl/core/csp_out_stage.sv]
module csp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  csp_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output csp_pkg::t_result o_res
);
    import csp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load only on a transfer into the register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

[rtl/core/cursor_shape_pixel_decoder.sv]
// Cursor shape pixel decoder. Takes one cursor image item per transfer on the
// s_axis side and gives per-pixel results on the m_axis side, keeping its own
// column and row position. Color and masked-color items yield one result each
// and stream at one item per clock while the output is not stalled. A monochrome
// item yields min(8, width - column) results, one per clock from the shared
// pixel engine unless the output stalls, and holds the input until its last
// result is taken. Any item seen while an error is latched gives one error
// result. Results leave through an output register that lets the next item be
// taken while a result waits. Configuration must be written through the cfg
// port only while idle; the block does not enforce this. Every register write
// restarts the image at column 0, row 0 and clears the latched error.
module cursor_shape_pixel_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [csp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // blue_in, green_in, red_in, alpha_in, and_mask_byte, xor_mask_byte
    input  logic [47:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out, pixel_alpha
    output logic [47:0]                    m_axis_tdata,
    // pixel_mode, error_code
    output logic [3:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import csp_pkg::*;

    t_cfg    cfg;
    logic    cfg_clear;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;

    csp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clear     (cfg_clear)
    );

    csp_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_clear      (cfg_clear),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (s_axis_tdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    csp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.pixel_alpha, out_res.blue_out, out_res.green_out,
                           out_res.red_out, out_res.pixel_y, out_res.pixel_x};
    assign m_axis_tuser = {out_res.error_code, out_res.pixel_mode};
    assign m_axis_tlast = out_res.last_of_item;

endmodule
